FILE: rtl/hsv_to_rgb_pixel_assert.svh
// Assertion macros shared by the HSV to RGB pixel converter.
`ifndef HSV_TO_RGB_PIXEL_ASSERT_SVH
`define HSV_TO_RGB_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define HSVP_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_pixel: assertion failed");
`define HSVP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_pixel: assertion failed");
`else
`define HSVP_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define HSVP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/hsvp_pkg.sv
// Package with the widths, constants and types of the HSV to RGB pixel converter.
package hsvp_pkg;

  localparam int HueW   = 13;
  localparam int HueIdW = 12;
  localparam int SvW    = 9;
  localparam int ChanW  = 8;
  localparam int MagW   = 21;
  localparam int ProdW  = 29;
  localparam int FracShift = 28;

  localparam logic [SvW-1:0]  SvOne  = 9'd256;
  localparam logic [HueIdW:0] HueOne = 13'd4096;
  localparam logic [MagW-1:0] MagOne = 21'h100000;

  typedef struct packed {
    logic mul_en;
    logic out_en;
  } hsvp_adv_t;

endpackage

FILE: rtl/hsv_to_rgb_pixel.sv
// Top level of the HSV to RGB pixel converter.
// An accepted word passes stages one to four to the output port. A stage moves whenever
// it is empty or drained; one word is accepted every cycle while in_stall_o is low.
// Stage depth is set by the sector multipliers and by the value multiplier of each channel.
// Reset clears all stage valid bits; the data registers are not reset.
`include "hsv_to_rgb_pixel_assert.svh"

module hsv_to_rgb_pixel import hsvp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [SvW-1:0]   saturation_i,
  input  logic [SvW-1:0]   brightness_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  typedef enum logic [2:0] {
    SecRy = 3'd0,
    SecYg = 3'd1,
    SecGc = 3'd2,
    SecCb = 3'd3,
    SecBm = 3'd4,
    SecMr = 3'd5
  } sector_e;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // The hue is taken modulo one turn and scaled by six into sector and fraction.
  logic [HueIdW-1:0]   hue_w;
  logic [HueIdW+2:0]   hue6;
  sector_e             s1_sector_d, s1_sector_q;
  logic [HueIdW-1:0]   s1_frac_d, s1_frac_q;
  logic [SvW-1:0]      s1_sat_d, s1_sat_q;
  logic [SvW-1:0]      s1_val_d, s1_val_q;

  assign hue_w       = hue_i[HueIdW-1:0];
  assign hue6        = {1'b0, hue_w, 2'b00} + {2'b00, hue_w, 1'b0};
  assign s1_sector_d = sector_e'(hue6[HueIdW+2:HueIdW]);
  assign s1_frac_d   = hue6[HueIdW-1:0];
  assign s1_sat_d    = (saturation_i > SvOne) ? SvOne : saturation_i;
  assign s1_val_d    = (brightness_i > SvOne) ? SvOne : brightness_i;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_sector_q <= s1_sector_d;
      s1_frac_q   <= s1_frac_d;
      s1_sat_q    <= s1_sat_d;
      s1_val_q    <= s1_val_d;
    end
  end

  logic [MagW-1:0]   sat_frac, sat_frac_c, mag_a, mag_b, mag_c;
  logic [HueIdW:0]   frac_c;
  logic [MagW-1:0]   s2_mr_d, s2_mg_d, s2_mb_d;
  logic [MagW-1:0]   s2_mr_q, s2_mg_q, s2_mb_q;
  logic [SvW-1:0]    s2_val_q;

  assign frac_c     = HueOne - {1'b0, s1_frac_q};
  assign sat_frac   = MagW'(s1_sat_q) * MagW'(s1_frac_q);
  assign sat_frac_c = MagW'(s1_sat_q) * MagW'(frac_c);
  assign mag_a      = {SvOne - s1_sat_q, {HueIdW{1'b0}}};
  assign mag_b      = MagOne - sat_frac;
  assign mag_c      = MagOne - sat_frac_c;

  always_comb begin
    unique case (s1_sector_q)
      SecRy: begin
        s2_mr_d = MagOne; s2_mg_d = mag_c;  s2_mb_d = mag_a;
      end
      SecYg: begin
        s2_mr_d = mag_b;  s2_mg_d = MagOne; s2_mb_d = mag_a;
      end
      SecGc: begin
        s2_mr_d = mag_a;  s2_mg_d = MagOne; s2_mb_d = mag_c;
      end
      SecCb: begin
        s2_mr_d = mag_a;  s2_mg_d = mag_b;  s2_mb_d = MagOne;
      end
      SecBm: begin
        s2_mr_d = mag_c;  s2_mg_d = mag_a;  s2_mb_d = MagOne;
      end
      default: begin
        s2_mr_d = MagOne; s2_mg_d = mag_a;  s2_mb_d = mag_b;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_mr_q  <= s2_mr_d;
      s2_mg_q  <= s2_mg_d;
      s2_mb_q  <= s2_mb_d;
      s2_val_q <= s1_val_q;
    end
  end

  hsvp_adv_t adv;

  assign adv.mul_en = rdy3;
  assign adv.out_en = rdy4;

  hsvp_chan u_red (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (s2_val_q),
    .mag_i  (s2_mr_q),
    .chan_o (red_o)
  );

  hsvp_chan u_green (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (s2_val_q),
    .mag_i  (s2_mg_q),
    .chan_o (green_o)
  );

  hsvp_chan u_blue (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (s2_val_q),
    .mag_i  (s2_mb_q),
    .chan_o (blue_o)
  );

  `HSVP_ASSERT_IMPLY(a_sector_range, clk_i, rst_ni, v1_q, s1_sector_q <= SecMr)
  `HSVP_ASSERT_IMPLY(a_clamped, clk_i, rst_ni, v1_q,
                     (s1_sat_q <= SvOne) && (s1_val_q <= SvOne))
  `HSVP_ASSERT_NEXT(a_grey, clk_i, rst_ni, v1_q && rdy2 && (s1_sat_q == '0),
                    (s2_mr_q == MagOne) && (s2_mg_q == MagOne) && (s2_mb_q == MagOne))
  `HSVP_ASSERT_NEXT(a_hold_stage3, clk_i, rst_ni, v3_q && !rdy4, v3_q)

endmodule

FILE: rtl/hsvp_chan.sv
// One color channel: scales the channel magnitude by the value and maps it to eight bits.
module hsvp_chan import hsvp_pkg::*; (
  input  logic             clk_i,
  input  hsvp_adv_t        adv_i,
  input  logic [SvW-1:0]   val_i,
  input  logic [MagW-1:0]  mag_i,
  output logic [ChanW-1:0] chan_o
);

  logic [ProdW:0]         mul_full;
  logic [ProdW-1:0]       prod_d, prod_q;
  logic [ProdW+ChanW-1:0] scaled;
  logic [ChanW-1:0]       chan_d, chan_q;

  assign mul_full = (ProdW+1)'(val_i) * (ProdW+1)'(mag_i);
  assign prod_d   = mul_full[ProdW-1:0];

  assign scaled = {prod_q, {ChanW{1'b0}}} - {{ChanW{1'b0}}, prod_q};
  assign chan_d = scaled[FracShift+ChanW-1:FracShift];

  always_ff @(posedge clk_i) begin
    if (adv_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (adv_i.out_en) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule
